// ===== rtl/ttq_pkg.sv =====
`default_nettype none

package ttq_pkg;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_WAKE    = 2'd1,
      EV_PREVIEW = 2'd2,
      EV_TAP     = 2'd3
   } event_kind_type;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_DELAY     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOVE_TOLERANCE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MENU_MIN_DELAY = 2'd2;

   localparam int HOLD_DELAY_BITS     = 9;
   localparam int MOVE_TOLERANCE_BITS = 8;
   localparam int MENU_DELAY_BITS     = 10;

   localparam logic [HOLD_DELAY_BITS-1:0]     HOLD_DELAY_RESET     = 9'd150;
   localparam logic [MOVE_TOLERANCE_BITS-1:0] MOVE_TOLERANCE_RESET = 8'd18;
   localparam logic [MENU_DELAY_BITS-1:0]     MENU_MIN_DELAY_RESET = 10'd300;

   typedef struct packed {
      logic [HOLD_DELAY_BITS-1:0]     hold_delay_ms;
      logic [MOVE_TOLERANCE_BITS-1:0] move_tolerance;
      logic [MENU_DELAY_BITS-1:0]     menu_min_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic tracking;
      logic previewed;
      logic consumed;
      logic moved;
   } flags_type;

endpackage

`default_nettype wire

// ===== rtl/ttq_cfg_regs.sv =====
`default_nettype none

module ttq_cfg_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [ttq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ttq_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output ttq_pkg::cfg_type                         cfg
);

   ttq_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_delay_ms     <= ttq_pkg::HOLD_DELAY_RESET;
         cfg_ff.move_tolerance    <= ttq_pkg::MOVE_TOLERANCE_RESET;
         cfg_ff.menu_min_delay_ms <= ttq_pkg::MENU_MIN_DELAY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ttq_pkg::CSR_HOLD_DELAY: begin
               cfg_ff.hold_delay_ms <= csr_wdata[ttq_pkg::HOLD_DELAY_BITS-1:0];
            end
            ttq_pkg::CSR_MOVE_TOLERANCE: begin
               cfg_ff.move_tolerance <= csr_wdata[ttq_pkg::MOVE_TOLERANCE_BITS-1:0];
            end
            ttq_pkg::CSR_MENU_MIN_DELAY: begin
               cfg_ff.menu_min_delay_ms <= csr_wdata[ttq_pkg::MENU_DELAY_BITS-1:0];
            end
            default: begin
               // unused index: write is dropped
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/ttq_tap_logic.sv =====
`default_nettype none

module ttq_tap_logic #(
   parameter int COORD_BITS = 12,
   parameter int TIME_BITS  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire ttq_pkg::cfg_type      cfg,
   input  wire logic                  pressed,
   input  wire logic [COORD_BITS-1:0] pos_x,
   input  wire logic [COORD_BITS-1:0] pos_y,
   input  wire logic [TIME_BITS-1:0]  now_ms,
   input  wire logic                  asleep,
   input  wire logic                  on_menu,
   input  wire logic                  cancel,
   output logic [1:0]                 event_kind,
   output logic [COORD_BITS-1:0]      event_x,
   output logic [COORD_BITS-1:0]      event_y
);

   ttq_pkg::flags_type    flags_ff, flags_in, flags_cur;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in;
   logic [COORD_BITS-1:0] start_y_ff, start_y_in;
   logic [TIME_BITS-1:0]  start_time_ff, start_time_in;

   logic [COORD_BITS-1:0]              dx, dy, tol;
   logic                               far;
   logic [TIME_BITS-1:0]               elapsed;
   logic [ttq_pkg::MENU_DELAY_BITS-1:0] hold_ext, delay;
   ttq_pkg::event_kind_type            kind;

   always_comb begin
      dx       = (pos_x > start_x_ff) ? pos_x - start_x_ff : start_x_ff - pos_x;
      dy       = (pos_y > start_y_ff) ? pos_y - start_y_ff : start_y_ff - pos_y;
      tol      = COORD_BITS'(cfg.move_tolerance);
      far      = (dx > tol) || (dy > tol);
      elapsed  = now_ms - start_time_ff;   // wraps modulo 2^TIME_BITS
      hold_ext = ttq_pkg::MENU_DELAY_BITS'(cfg.hold_delay_ms);
      delay    = (on_menu && (hold_ext < cfg.menu_min_delay_ms)) ?
                 cfg.menu_min_delay_ms : hold_ext;
   end

   always_comb begin
      // cancel clears the flags before the poll is looked at
      flags_cur     = cancel ? '0 : flags_ff;
      flags_in      = flags_cur;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      start_time_in = start_time_ff;
      kind          = ttq_pkg::EV_NONE;
      event_x       = '0;
      event_y       = '0;

      if (pressed) begin
         if (!flags_cur.tracking) begin
            flags_in.tracking  = 1'b1;
            flags_in.previewed = !asleep;
            flags_in.consumed  = asleep;
            flags_in.moved     = 1'b0;
            start_x_in         = pos_x;
            start_y_in         = pos_y;
            start_time_in      = now_ms;
            if (asleep) begin
               kind = ttq_pkg::EV_WAKE;
            end else begin
               kind    = ttq_pkg::EV_PREVIEW;
               event_x = pos_x;
               event_y = pos_y;
            end
         end else if (!flags_cur.consumed) begin
            if (!far && !flags_cur.moved && (elapsed >= TIME_BITS'(delay))) begin
               flags_in.consumed = 1'b1;
               kind              = ttq_pkg::EV_TAP;
               event_x           = start_x_ff;
               event_y           = start_y_ff;
            end else if (far && flags_cur.previewed) begin
               flags_in.moved = 1'b1;
               start_x_in     = pos_x;
               start_y_in     = pos_y;
               start_time_in  = now_ms;
               kind           = ttq_pkg::EV_PREVIEW;
               event_x        = pos_x;
               event_y        = pos_y;
            end
         end
      end else begin
         // release before the hold delay still counts as a tap
         if (flags_cur.tracking && !flags_cur.consumed && flags_cur.previewed &&
             !flags_cur.moved) begin
            kind    = ttq_pkg::EV_TAP;
            event_x = start_x_ff;
            event_y = start_y_ff;
         end
         flags_in = '0;
      end
   end

   assign event_kind = kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff      <= '0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         start_time_ff <= '0;
      end else if (step_en) begin
         flags_ff      <= flags_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         start_time_ff <= start_time_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/touch_tap_qualifier_core.sv =====
`default_nettype none

// Channel   Ports                                           Direction
// req       req_valid/req_ready, pressed, pos, now, flags   in
// rsp       rsp_valid/rsp_ready, event_kind, event_x/y      out
// csr       csr_wr_en, csr_index, csr_wdata (write only)    in
//
// One transfer per cycle sustained while results are taken; a poll's event goes
// into the result register, with rsp_valid, as it leaves the input register.
// The touch state is updated as a poll moves from the input register into
// the result register, so consecutive polls see each other's effects.
// Synchronous reset clears the touch state and loads the register defaults.
// A stalled result holds the input register; req_ready stays high while the
// input register is empty, or the result register is empty or being taken.

module touch_tap_qualifier_core #(
   parameter int COORD_BITS = 12,
   parameter int TIME_BITS  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_pressed,
   input  wire logic [COORD_BITS-1:0]               req_pos_x,
   input  wire logic [COORD_BITS-1:0]               req_pos_y,
   input  wire logic [31:0]                         req_now_ms,
   input  wire logic                                req_asleep,
   input  wire logic                                req_on_menu,
   input  wire logic                                req_cancel,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_event_kind,
   output logic [COORD_BITS-1:0]                    rsp_event_x,
   output logic [COORD_BITS-1:0]                    rsp_event_y,

   input  wire logic                                csr_wr_en,
   input  wire logic [ttq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ttq_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   ttq_pkg::cfg_type cfg;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_pressed_ff, in_asleep_ff, in_on_menu_ff, in_cancel_ff;
   logic [COORD_BITS-1:0] in_pos_x_ff, in_pos_y_ff;
   logic [TIME_BITS-1:0]  in_now_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_kind_ff;
   logic [COORD_BITS-1:0] out_x_ff, out_y_ff;

   logic                  out_free, advance, req_take;
   logic [1:0]            ev_kind;
   logic [COORD_BITS-1:0] ev_x, ev_y;

   ttq_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ttq_tap_logic #(
      .COORD_BITS (COORD_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_logic (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .cfg        (cfg),
      .pressed    (in_pressed_ff),
      .pos_x      (in_pos_x_ff),
      .pos_y      (in_pos_y_ff),
      .now_ms     (in_now_ff),
      .asleep     (in_asleep_ff),
      .on_menu    (in_on_menu_ff),
      .cancel     (in_cancel_ff),
      .event_kind (ev_kind),
      .event_x    (ev_x),
      .event_y    (ev_y)
   );

   assign out_free     = !out_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || out_free;
   assign req_take     = req_valid && req_ready;
   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pressed_ff <= req_pressed;
         in_pos_x_ff   <= req_pos_x;
         in_pos_y_ff   <= req_pos_y;
         in_now_ff     <= req_now_ms[TIME_BITS-1:0];
         in_asleep_ff  <= req_asleep;
         in_on_menu_ff <= req_on_menu;
         in_cancel_ff  <= req_cancel;
      end
      if (advance) begin
         out_kind_ff <= ev_kind;
         out_x_ff    <= ev_x;
         out_y_ff    <= ev_y;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_event_x    = out_x_ff;
   assign rsp_event_y    = out_y_ff;

endmodule

`default_nettype wire

// ===== bench/tb_touch_tap_qualifier_core.sv =====
module tb_touch_tap_qualifier_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        pressed;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [31:0] now_ms;
      logic        asleep;
      logic        on_menu;
      logic        cancel;
   } poll_type;

   typedef struct {
      ttq_pkg::event_kind_type kind;
      logic [11:0]             x;
      logic [11:0]             y;
   } touch_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_pressed = 1'b0;
   logic [11:0] req_pos_x = '0;
   logic [11:0] req_pos_y = '0;
   logic [31:0] req_now_ms = '0;
   logic        req_asleep = 1'b0;
   logic        req_on_menu = 1'b0;
   logic        req_cancel = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [11:0] rsp_event_x;
   logic [11:0] rsp_event_y;

   logic                               csr_wr_en = 1'b0;
   logic [ttq_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ttq_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   touch_tap_qualifier_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pressed    (req_pressed),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_now_ms     (req_now_ms),
      .req_asleep     (req_asleep),
      .req_on_menu    (req_on_menu),
      .req_cancel     (req_cancel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_event_x    (rsp_event_x),
      .rsp_event_y    (rsp_event_y),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // touch tracker shadow
   ttq_pkg::cfg_type   shadow_cfg = '{ttq_pkg::HOLD_DELAY_RESET, ttq_pkg::MOVE_TOLERANCE_RESET,
                                      ttq_pkg::MENU_MIN_DELAY_RESET};
   ttq_pkg::flags_type touch_flags = '0;
   logic [11:0] anchor_x = '0;
   logic [11:0] anchor_y = '0;
   logic [31:0] anchor_ms = '0;

   poll_type        poll_queue[$];
   touch_event_type pending_events[$];
   logic         req_fired = 1'b0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  fault_count = 0;
   int unsigned  polls_queued = 0;
   logic [31:0]  poll_ms = '0;

   function automatic logic [11:0] axis_gap(input logic [11:0] a, input logic [11:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic touch_event_type next_event(input poll_type p);
      touch_event_type ev;
      logic         far_off;
      logic [9:0]   delay;
      logic [31:0]  elapsed;
      ev = '{kind: ttq_pkg::EV_NONE, x: '0, y: '0};
      if (p.cancel)
         touch_flags = '0;
      if (p.pressed) begin
         if (!touch_flags.tracking) begin
            touch_flags = '{tracking: 1'b1, previewed: !p.asleep, consumed: p.asleep,
                            moved: 1'b0};
            anchor_x  = p.pos_x;
            anchor_y  = p.pos_y;
            anchor_ms = p.now_ms;
            if (p.asleep)
               ev.kind = ttq_pkg::EV_WAKE;
            else
               ev = '{kind: ttq_pkg::EV_PREVIEW, x: p.pos_x, y: p.pos_y};
         end else if (!touch_flags.consumed) begin
            far_off = axis_gap(p.pos_x, anchor_x) > shadow_cfg.move_tolerance ||
                      axis_gap(p.pos_y, anchor_y) > shadow_cfg.move_tolerance;
            delay = {1'b0, shadow_cfg.hold_delay_ms};
            if (p.on_menu && delay < shadow_cfg.menu_min_delay_ms)
               delay = shadow_cfg.menu_min_delay_ms;
            elapsed = p.now_ms - anchor_ms;   // wraps at 32 bits
            if (!far_off && !touch_flags.moved && elapsed >= delay) begin
               touch_flags.consumed = 1'b1;
               ev = '{kind: ttq_pkg::EV_TAP, x: anchor_x, y: anchor_y};
            end else if (far_off && touch_flags.previewed) begin
               touch_flags.moved = 1'b1;
               anchor_x  = p.pos_x;
               anchor_y  = p.pos_y;
               anchor_ms = p.now_ms;
               ev = '{kind: ttq_pkg::EV_PREVIEW, x: p.pos_x, y: p.pos_y};
            end
         end
      end else begin
         if (touch_flags.tracking && !touch_flags.consumed && touch_flags.previewed &&
             !touch_flags.moved)
            ev = '{kind: ttq_pkg::EV_TAP, x: anchor_x, y: anchor_y};
         touch_flags = '0;
      end
      return ev;
   endfunction

   // driver: a new poll is offered only once the previous one has transferred
   always @(negedge clock) begin : poll_driver
      poll_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (poll_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            p = poll_queue.pop_front();
            req_valid   <= 1'b1;
            req_pressed <= p.pressed;
            req_pos_x   <= p.pos_x;
            req_pos_y   <= p.pos_y;
            req_now_ms  <= p.now_ms;
            req_asleep  <= p.asleep;
            req_on_menu <= p.on_menu;
            req_cancel  <= p.cancel;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : event_monitor
      touch_event_type want;
      poll_type        seen;
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               $error("event transfer with nothing expected: kind %0d x %0d y %0d",
                      rsp_event_kind, rsp_event_x, rsp_event_y);
               fault_count++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_event_kind !== want.kind) begin
                  $error("event_kind: expected %0d, got %0d", want.kind, rsp_event_kind);
                  fault_count++;
               end
               if (rsp_event_x !== want.x) begin
                  $error("event_x: expected %0d, got %0d", want.x, rsp_event_x);
                  fault_count++;
               end
               if (rsp_event_y !== want.y) begin
                  $error("event_y: expected %0d, got %0d", want.y, rsp_event_y);
                  fault_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            seen = '{req_pressed, req_pos_x, req_pos_y, req_now_ms, req_asleep,
                     req_on_menu, req_cancel};
            pending_events.push_back(next_event(seen));
            req_fired = 1'b1;
         end
      end
   end

   task automatic add_poll(input logic pressed, input logic [11:0] x, input logic [11:0] y,
                           input logic asleep, input logic on_menu, input logic cancel,
                           input int unsigned step_ms);
      poll_ms = poll_ms + step_ms;
      poll_queue.push_back('{pressed, x, y, poll_ms, asleep, on_menu, cancel});
      polls_queued++;
   endtask

   // wait for the block to go quiet, then leave a margin before the next step
   task automatic settle();
      do
         @(negedge clock);
      while (poll_queue.size() != 0 || req_valid || pending_events.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [ttq_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [ttq_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         ttq_pkg::CSR_HOLD_DELAY:
            shadow_cfg.hold_delay_ms = data[ttq_pkg::HOLD_DELAY_BITS-1:0];
         ttq_pkg::CSR_MOVE_TOLERANCE:
            shadow_cfg.move_tolerance = data[ttq_pkg::MOVE_TOLERANCE_BITS-1:0];
         ttq_pkg::CSR_MENU_MIN_DELAY:
            shadow_cfg.menu_min_delay_ms = data[ttq_pkg::MENU_DELAY_BITS-1:0];
         default: ;
      endcase
   endtask

   // one touch: press, a few held polls with jitter around the start, mostly a release
   task automatic push_touch();
      int          holds;
      int          reach;
      int          dx;
      int          dy;
      logic [11:0] x0;
      logic [11:0] y0;
      logic        sleepy;
      logic        menu;
      x0     = 12'($urandom);
      y0     = 12'($urandom);
      sleepy = ($urandom_range(0, 7) == 0);
      menu   = ($urandom_range(0, 3) == 0);
      holds  = $urandom_range(0, 7);
      add_poll(1'b1, x0, y0, sleepy, menu, $urandom_range(0, 15) == 0,
               $urandom_range(1, 400));
      for (int i = 0; i < holds; i++) begin
         reach = shadow_cfg.move_tolerance +
                 (($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 0);
         dx = $urandom_range(0, 2 * reach) - reach;
         dy = $urandom_range(0, 2 * reach) - reach;
         add_poll(1'b1, 12'(x0 + dx), 12'(y0 + dy), sleepy, menu,
                  $urandom_range(0, 29) == 0, $urandom_range(0, 160));
      end
      if ($urandom_range(0, 7) != 0)
         add_poll(1'b0, 12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
                  $urandom_range(0, 19) == 0, $urandom_range(0, 200));
   endtask

   task automatic run_random(input int unsigned n);
      int unsigned target;
      target = polls_queued + n;
      while (polls_queued < target) begin
         if ($urandom_range(0, 9) == 0) begin
            poll_ms = $urandom;
            add_poll(1'($urandom), 12'($urandom), 12'($urandom), 1'($urandom),
                     1'($urandom), 1'($urandom), 0);
         end else begin
            push_touch();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin : stimulus
      logic [ttq_pkg::CSR_DATA_BITS-1:0] hold_set[6] = '{10'd50, 10'd500, 10'h3FF, 10'd50,
                                                         10'd200, 10'd150};
      logic [ttq_pkg::CSR_DATA_BITS-1:0] tol_set[6]  = '{10'd0, 10'd255, 10'd255, 10'd18,
                                                         10'd40, 10'd5};
      logic [ttq_pkg::CSR_DATA_BITS-1:0] menu_set[6] = '{10'd0, 10'd1023, 10'd0, 10'd1023,
                                                         10'd300, 10'd600};
      wait (!reset);
      @(negedge clock);
      send_idle_pct = 17;
      recv_idle_pct = 46;

      // directed, reset register values
      add_poll(1'b1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, 0);          // preview at time zero
      add_poll(1'b1, 12'd18, 12'd18, 1'b0, 1'b0, 1'b0, 149);      // on tolerance, 1 ms short
      add_poll(1'b1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1);          // tap exactly at delay
      add_poll(1'b1, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, 10);
      add_poll(1'b0, 12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, 5);
      add_poll(1'b1, 12'd4095, 12'd4095, 1'b1, 1'b1, 1'b0, 5);    // wake
      add_poll(1'b1, 12'd4095, 12'd4095, 1'b1, 1'b1, 1'b0, 900);  // swallowed press
      add_poll(1'b0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, 5);
      add_poll(1'b1, 12'd100, 12'd200, 1'b0, 1'b0, 1'b0, 5);
      add_poll(1'b0, 12'd100, 12'd200, 1'b0, 1'b0, 1'b0, 20);     // early release taps
      add_poll(1'b1, 12'd2000, 12'd2000, 1'b0, 1'b0, 1'b0, 5);
      add_poll(1'b1, 12'd2019, 12'd2000, 1'b0, 1'b0, 1'b0, 10);   // moved on x
      add_poll(1'b1, 12'd2019, 12'd2000, 1'b0, 1'b0, 1'b0, 400);  // no tap after a move
      add_poll(1'b1, 12'd2019, 12'd1981, 1'b0, 1'b0, 1'b0, 10);   // moved on y
      add_poll(1'b0, 12'd2019, 12'd1981, 1'b0, 1'b0, 1'b0, 5);
      add_poll(1'b1, 12'd500, 12'd500, 1'b0, 1'b1, 1'b0, 5);
      add_poll(1'b1, 12'd500, 12'd500, 1'b0, 1'b1, 1'b0, 299);    // menu minimum holds it
      add_poll(1'b1, 12'd500, 12'd500, 1'b0, 1'b1, 1'b0, 1);
      add_poll(1'b1, 12'd600, 12'd600, 1'b0, 1'b0, 1'b1, 5);      // cancel then fresh press
      add_poll(1'b0, 12'd600, 12'd600, 1'b0, 1'b0, 1'b1, 5);
      poll_ms = 32'hFFFF_FFA0;
      add_poll(1'b1, 12'd1234, 12'd2345, 1'b0, 1'b0, 1'b0, 0);
      add_poll(1'b1, 12'd1234, 12'd2345, 1'b0, 1'b0, 1'b0, 32'h70);  // across the wrap
      add_poll(1'b1, 12'd1234, 12'd2345, 1'b0, 1'b0, 1'b0, 48);
      poll_ms = 32'hFFFF_FFFF;
      add_poll(1'b0, 12'd4095, 12'd4095, 1'b1, 1'b1, 1'b1, 0);
      add_poll(1'b1, 12'd4095, 12'd0, 1'b1, 1'b0, 1'b1, 1);
      add_poll(1'b0, 12'd0, 12'd4095, 1'b0, 1'b1, 1'b0, 1);
      settle();

      for (int s = 0; s < 6; s++) begin
         send_idle_pct = (s < 2) ? 17 : (s < 4) ? 46 : 0;
         recv_idle_pct = (s < 2) ? 46 : (s < 4) ? 17 : 0;
         write_csr(ttq_pkg::CSR_HOLD_DELAY, hold_set[s]);
         write_csr(ttq_pkg::CSR_MOVE_TOLERANCE, tol_set[s]);
         write_csr(ttq_pkg::CSR_MENU_MIN_DELAY, menu_set[s]);
         run_random(90);
         settle();   // sender holds off until the block has drained
         run_random(90);
         settle();
      end

      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
